@@ hw/rtl/qts_pkg.sv @@
// Shared types and constants for the quoted token splitter.
package qts_pkg;

	localparam int MAX_RUN        = 5;
	localparam int RUN_CNT_W      = 3;
	localparam int CFG_W          = 64;
	localparam int CFG_IDX_W      = 2;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM_HI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EMIT     = 2'd2;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_END   = 2'd1,
		KIND_DELIM = 2'd2,
		KIND_EOI   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
	} slot_t;

	typedef struct packed {
		slot_t [MAX_RUN-1:0]  slot;
		logic [RUN_CNT_W-1:0] cnt;
	} run_t;

endpackage

@@ hw/rtl/qts_front.sv @@
// Front end: configuration, byte classification and tokenizer state.
module qts_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [qts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qts_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_accept,
	input  logic [7:0]                    in_char,
	input  logic                          end_of_input,
	output logic                          push,
	output qts_pkg::run_t                 run
);
	import qts_pkg::*;

	logic [CFG_W-1:0] delim_lo_q;
	logic [CFG_W-1:0] delim_hi_q;
	logic             emit_q;

	logic token_open_q, quote_q, comment_q, slash_q;
	logic token_open_d, quote_d, comment_d, slash_d;

	logic is_delim;
	logic is_ws;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_lo_q <= '0;
			delim_hi_q <= '0;
			emit_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELIM_LO: delim_lo_q <= cfg_data;
				CFG_DELIM_HI: delim_hi_q <= cfg_data;
				CFG_EMIT:     emit_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (in_char[7])
			is_delim = 1'b0;
		else if (in_char[6])
			is_delim = delim_hi_q[in_char[5:0]];
		else
			is_delim = delim_lo_q[in_char[5:0]];
	end

	assign is_ws = (in_char == CH_SPACE) || (in_char == CH_TAB) || (in_char == CH_NUL) ||
	               (in_char == CH_CR) || (in_char == CH_LF);

	always_comb begin
		logic [RUN_CNT_W-1:0] n;
		logic                 done;
		n            = '0;
		done         = 1'b0;
		run          = '0;
		token_open_d = token_open_q;
		quote_d      = quote_q;
		comment_d    = comment_q;
		slash_d      = slash_q;

		if (comment_q) begin
			if (in_char == CH_LF)
				comment_d = 1'b0;
		end else if (quote_q) begin
			if (in_char == CH_DQUOTE) begin
				quote_d = 1'b0;
				if (token_open_d) begin
					run.slot[n]  = slot_t'{kind: KIND_END, ch: 8'h00};
					n            = n + 3'd1;
					token_open_d = 1'b0;
				end
			end else begin
				run.slot[n]  = slot_t'{kind: KIND_BYTE, ch: in_char};
				n            = n + 3'd1;
				token_open_d = 1'b1;
			end
		end else begin
			if (slash_q) begin
				slash_d = 1'b0;
				if (in_char == CH_SLASH) begin
					if (token_open_d) begin
						run.slot[n]  = slot_t'{kind: KIND_END, ch: 8'h00};
						n            = n + 3'd1;
						token_open_d = 1'b0;
					end
					comment_d = 1'b1;
					done      = 1'b1;
				end else begin
					run.slot[n]  = slot_t'{kind: KIND_BYTE, ch: CH_SLASH};
					n            = n + 3'd1;
					token_open_d = 1'b1;
				end
			end
			if (!done) begin
				if (is_delim) begin
					if (token_open_d) begin
						run.slot[n]  = slot_t'{kind: KIND_END, ch: 8'h00};
						n            = n + 3'd1;
						token_open_d = 1'b0;
					end
					if (emit_q) begin
						run.slot[n] = slot_t'{kind: KIND_DELIM, ch: in_char};
						n           = n + 3'd1;
					end
				end else if (is_ws) begin
					if (token_open_d) begin
						run.slot[n]  = slot_t'{kind: KIND_END, ch: 8'h00};
						n            = n + 3'd1;
						token_open_d = 1'b0;
					end
				end else if (in_char == CH_DQUOTE) begin
					quote_d = 1'b1;
				end else if (in_char == CH_SLASH) begin
					slash_d = 1'b1;
				end else begin
					run.slot[n]  = slot_t'{kind: KIND_BYTE, ch: in_char};
					n            = n + 3'd1;
					token_open_d = 1'b1;
				end
			end
		end

		if (end_of_input) begin
			if (slash_d) begin
				run.slot[n]  = slot_t'{kind: KIND_BYTE, ch: CH_SLASH};
				n            = n + 3'd1;
				token_open_d = 1'b1;
			end
			if (token_open_d) begin
				run.slot[n] = slot_t'{kind: KIND_END, ch: 8'h00};
				n           = n + 3'd1;
			end
			run.slot[n]  = slot_t'{kind: KIND_EOI, ch: 8'h00};
			n            = n + 3'd1;
			token_open_d = 1'b0;
			quote_d      = 1'b0;
			comment_d    = 1'b0;
			slash_d      = 1'b0;
		end

		run.cnt = n;
	end

	assign push = in_accept && (run.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_open_q <= 1'b0;
			quote_q      <= 1'b0;
			comment_q    <= 1'b0;
			slash_q      <= 1'b0;
		end else if (in_accept) begin
			token_open_q <= token_open_d;
			quote_q      <= quote_d;
			comment_q    <= comment_d;
			slash_q      <= slash_d;
		end
	end

endmodule

@@ hw/rtl/qts_queue.sv @@
// Run queue between the front end and the output sequencer.
module qts_queue #(
	parameter int DEPTH = qts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qts_pkg::run_t push_run,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output qts_pkg::run_t head_run
);
	import qts_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	run_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_run  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

@@ hw/rtl/qts_back.sv @@
// Output sequencer: holds one run and issues its results one per cycle while out_stall is low.
module qts_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          run_valid,
	input  qts_pkg::run_t head_run,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    kind,
	output logic [7:0]    out_char,
	output logic          last_of_run
);
	import qts_pkg::*;

	run_t                 cur_q;
	logic [RUN_CNT_W-1:0] idx_q;
	logic                 busy_q;
	logic                 out_accept;
	slot_t                cur_slot;

	assign cur_slot    = cur_q.slot[idx_q];
	assign out_valid   = busy_q;
	assign kind        = cur_slot.kind;
	assign out_char    = cur_slot.ch;
	assign last_of_run = (idx_q == cur_q.cnt - 3'd1);
	assign out_accept  = busy_q && !out_stall;
	assign pop         = run_valid && (!busy_q || (out_accept && last_of_run));

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_accept) begin
			if (last_of_run)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 3'd1;
		end
	end

endmodule

@@ hw/rtl/quoted_token_splitter.sv @@
// Top level of the quoted token splitter.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  input   | in        | in_valid / in_stall | in_char, end_of_input
//  output  | out       | out_valid/out_stall | kind, out_char, last_of_run
//  config  | in        | cfg_we              | cfg_index, cfg_data
//
// One byte is taken every cycle while the run queue has room; each byte's results
// (up to four) form one queue entry, and the sequencer issues one result per cycle
// while out_stall is low; a byte without results makes no queue entry.
// The sequencer takes the head run when idle or when its last result is taken.
// Reset clears the tokenizer state, the configuration and the queue.
// in_stall is high while the queue is full; out_stall holds the current result.
module quoted_token_splitter #(
	parameter int QUEUE_DEPTH = qts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [qts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qts_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_char,
	input  logic                          end_of_input,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [7:0]                    out_char,
	output logic                          last_of_run
);
	import qts_pkg::*;

	logic in_accept;
	logic push;
	logic pop;
	logic full;
	logic not_empty;
	run_t push_run;
	run_t head_run;

	assign in_stall  = full;
	assign in_accept = in_valid && !full;

	qts_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_accept    (in_accept),
		.in_char      (in_char),
		.end_of_input (end_of_input),
		.push         (push),
		.run          (push_run)
	);

	qts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_run  (push_run),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head_run  (head_run)
	);

	qts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.run_valid   (not_empty),
		.head_run    (head_run),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("run ended before its last result");

	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_EOI) |-> last_of_run)
		else $error("end of input is not the last result of its run");

	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((kind == KIND_END) || (kind == KIND_EOI)) |-> (out_char == 8'h00))
		else $error("end mark carries a nonzero byte");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("run pushed into a full queue");

endmodule

@@ verif/token_checker.sv @@
// Predicts the splitter's results from the observed channels and compares them.
`timescale 1ns / 1ps

module token_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [qts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qts_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [7:0]                    in_char,
	input  logic                          end_of_input,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [1:0]                    kind,
	input  logic [7:0]                    out_char,
	input  logic                          last_of_run,
	output int                            errors,
	output int                            pending
);
	import qts_pkg::*;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       last;
	} token_ev_t;

	token_ev_t   want_q[$];
	token_ev_t   run_buf[MAX_RUN];
	int          run_len;
	token_ev_t   got_ev;

	logic [63:0] delim_lo;
	logic [63:0] delim_hi;
	logic        emit_delim;

	logic        in_token;
	logic        in_quote;
	logic        in_comment;
	logic        slash_pending;

	function automatic logic is_delim(logic [7:0] c);
		if (c < 8'd64)
			return delim_lo[c[5:0]];
		if (c < 8'd128)
			return delim_hi[c[5:0]];
		return 1'b0;
	endfunction

	function automatic void push_run(kind_t k, logic [7:0] c);
		run_buf[run_len].kind = k;
		run_buf[run_len].ch   = c;
		run_buf[run_len].last = 1'b0;
		run_len++;
	endfunction

	function automatic void close_token();
		if (in_token) begin
			push_run(KIND_END, 8'h00);
			in_token = 1'b0;
		end
	endfunction

	function automatic void add_token_byte(logic [7:0] c);
		push_run(KIND_BYTE, c);
		in_token = 1'b1;
	endfunction

	function automatic void handle_byte(logic [7:0] c);
		if (in_comment) begin
			if (c == CH_LF)
				in_comment = 1'b0;
			return;
		end
		if (in_quote) begin
			if (c == CH_DQUOTE) begin
				in_quote = 1'b0;
				close_token();
			end else begin
				add_token_byte(c);
			end
			return;
		end
		if (slash_pending) begin
			slash_pending = 1'b0;
			if (c == CH_SLASH) begin
				close_token();
				in_comment = 1'b1;
				return;
			end
			add_token_byte(CH_SLASH);
		end
		if (is_delim(c)) begin
			close_token();
			if (emit_delim)
				push_run(KIND_DELIM, c);
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_NUL ||
				c == CH_CR || c == CH_LF) begin
			close_token();
		end else if (c == CH_DQUOTE) begin
			in_quote = 1'b1;
		end else if (c == CH_SLASH) begin
			slash_pending = 1'b1;
		end else begin
			add_token_byte(c);
		end
	endfunction

	function automatic void scan_byte(logic [7:0] c, logic eoi);
		token_ev_t ev;
		run_len = 0;
		handle_byte(c);
		if (eoi) begin
			if (slash_pending) begin
				slash_pending = 1'b0;
				add_token_byte(CH_SLASH);
			end
			close_token();
			push_run(KIND_EOI, 8'h00);
			in_token      = 1'b0;
			in_quote      = 1'b0;
			in_comment    = 1'b0;
			slash_pending = 1'b0;
		end
		for (int i = 0; i < run_len; i++) begin
			ev      = run_buf[i];
			ev.last = (i == run_len - 1);
			want_q.push_back(ev);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_lo      = '0;
			delim_hi      = '0;
			emit_delim    = 1'b0;
			in_token      = 1'b0;
			in_quote      = 1'b0;
			in_comment    = 1'b0;
			slash_pending = 1'b0;
			want_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DELIM_LO: delim_lo = cfg_data;
					CFG_DELIM_HI: delim_hi = cfg_data;
					CFG_EMIT:     emit_delim = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				scan_byte(in_char, end_of_input);
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0) begin
					errors = errors + 1;
					if (errors <= 10)
						$display("unexpected result: kind=%0d char=%02h last=%0b",
							kind, out_char, last_of_run);
				end else begin
					got_ev = want_q.pop_front();
					if (kind !== got_ev.kind || out_char !== got_ev.ch ||
							last_of_run !== got_ev.last) begin
						errors = errors + 1;
						if (errors <= 10)
							$display({"mismatch: expected kind=%0d char=%02h last=%0b,",
								" got kind=%0d char=%02h last=%0b"},
								got_ev.kind, got_ev.ch, got_ev.last,
								kind, out_char, last_of_run);
					end
				end
			end
			pending = want_q.size();
		end
	end

endmodule

@@ verif/quoted_token_splitter_tb.sv @@
// Stimulus, idling and verdict for the quoted token splitter.
`timescale 1ns / 1ps

module quoted_token_splitter_tb;
	import qts_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_BAR   = 8'h7c;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int SETTLE_CYCLES    = 16;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           in_char = 8'h00;
	logic                 end_of_input = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           kind;
	logic [7:0]           out_char;
	logic                 last_of_run;
	int                   errors;
	int                   pending;
	logic                 quiet = 1'b0;
	int                   idle_cycles = 0;

	quoted_token_splitter dut (.*);

	token_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (quiet)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < 31);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [7:0] c, input logic eoi);
		while (!quiet && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		in_char      <= c;
		end_of_input <= eoi;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
			input logic [63:0] emit);
		write_reg(CFG_DELIM_LO, lo);
		write_reg(CFG_DELIM_HI, hi);
		write_reg(CFG_EMIT, emit);
		write_reg(CFG_SPARE, {$urandom(), $urandom()});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 33)
			return 8'h61 + 8'($urandom_range(25));
		if (r < 47) begin
			case ($urandom_range(6))
				0: return CH_SPACE;
				1: return CH_TAB;
				2: return CH_NUL;
				3: return CH_CR;
				default: return CH_LF;
			endcase
		end
		if (r < 56)
			return CH_DQUOTE;
		if (r < 67)
			return CH_SLASH;
		if (r < 75) begin
			case ($urandom_range(2))
				0: return CH_COMMA;
				1: return CH_SEMI;
				default: return CH_BAR;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic random_run(input int n, input logic mid_drain);
		for (int i = 0; i < n; i++) begin
			send_item(pick_byte(), $urandom_range(29) == 0);
			if (mid_drain && i == n / 2)
				wait_idle();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		random_run(40, 1'b0);

		wait_idle();
		configure((64'd1 << CH_COMMA) | (64'd1 << CH_SEMI),
			(64'd1 << (CH_BAR - 8'd64)) | (64'd1 << (CH_DEL - 8'd64)), 64'd1);
		send_item(8'h61, 1'b0);
		send_item(8'hff, 1'b0);
		send_item(CH_SPACE, 1'b0);
		send_item(CH_DQUOTE, 1'b0);
		send_item(CH_DQUOTE, 1'b0);
		send_item(8'h78, 1'b0);
		send_item(CH_DQUOTE, 1'b0);
		send_item(CH_TAB, 1'b0);
		send_item(CH_COMMA, 1'b0);
		send_item(CH_DQUOTE, 1'b0);
		send_item(CH_COMMA, 1'b0);
		send_item(CH_SLASH, 1'b0);
		send_item(8'h71, 1'b0);
		send_item(CH_SLASH, 1'b0);
		send_item(CH_SLASH, 1'b0);
		send_item(8'h7a, 1'b0);
		send_item(CH_LF, 1'b0);
		send_item(CH_NUL, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(CH_CR, 1'b0);
		send_item(CH_BAR, 1'b0);
		send_item(CH_DEL, 1'b0);
		send_item(CH_SLASH, 1'b1);
		send_item(CH_DQUOTE, 1'b0);
		send_item(8'h6b, 1'b1);

		for (int p = 1; p <= 5; p++) begin
			wait_idle();
			case (p)
				1: configure('1, '1, 64'd1);
				2: configure('0, '0, 64'hffff_ffff_ffff_fffe);
				3: configure({$urandom(), $urandom()} & {$urandom(), $urandom()},
					{$urandom(), $urandom()} & {$urandom(), $urandom()},
					{$urandom(), $urandom()});
				4: configure({$urandom(), $urandom()} & {$urandom(), $urandom()} |
					(64'd1 << CH_SLASH) | (64'd1 << CH_DQUOTE),
					{$urandom(), $urandom()}, 64'd1);
				default: configure((64'd1 << CH_COMMA) | (64'd1 << CH_SEMI),
					(64'd1 << (CH_BAR - 8'd64)), 64'd1);
			endcase
			quiet <= (p == 1);
			random_run(80, p == 3);
		end

		wait_idle();
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
